>>> src/self_calibrating_fractional_clock_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractional clock unit
// Same-cycle-implication and next-cycle-implication concurrent property wrappers.
// ----------------------------------------------------------------------------
`ifndef SELF_CALIBRATING_FRACTIONAL_CLOCK_UNIT_ASSERT_SVH
`define SELF_CALIBRATING_FRACTIONAL_CLOCK_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the fractional clock unit.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // item modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;
  localparam logic [1:0] MODE_RATE = 2'd3;

  // one second in 32.32 fixed point, and the rate after reset (2^35)
  localparam logic [63:0] ONE_SEC    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] RATE_RESET = 64'h0000_0008_0000_0000;

  // step counter start values: 8 multiply steps, 64 divide steps
  localparam logic [5:0] MUL_START = 6'd7;
  localparam logic [5:0] DIV_START = 6'd63;

  // request to the shared adder
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

endpackage

>>> src/sfc_addsub.sv
// ----------------------------------------------------------------------------
// sfc_addsub
// Shared 64-bit adder/subtractor with carry out (carry set means a >= b
// when subtracting).
// ----------------------------------------------------------------------------
module sfc_addsub (
  input  sfc_pkg::alu_req_t req,
  output logic [63:0]       sum,
  output logic              carry
);

  logic [63:0] b_inv;

  // invert b for subtraction, carry in supplies the +1
  assign b_inv = req.b ^ {64{req.sub}};
  assign {carry, sum} = {1'b0, req.a} + {1'b0, b_inv} + {64'd0, req.sub};

endmodule

>>> src/self_calibrating_fractional_clock_unit.sv
// ----------------------------------------------------------------------------
// self_calibrating_fractional_clock_unit
// Disciplined 32.32 fixed-point time-of-day clock with rate recalibration.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives one result. A set-time loads the
// clock and then either records a new reference or recalibrates the rate. All
// time and rate arithmetic runs through one shared 64-bit adder (the tick and
// step counters have their own): the sub-count product is an 8-step shift-add,
// the recalibration a 64-step restoring divide, and the readback three adder steps. A
// finished result waits in the output registers; the next item is accepted
// meanwhile and only stalls at its readback step while the old result is
// still waiting.
module self_calibrating_fractional_clock_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_subcount,
  input  logic [31:0]        in_set_seconds,
  input  logic signed [31:0] in_rate_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_whole_seconds,
  output logic [63:0]        out_precise_time,
  output logic [31:0]        out_tick_count,
  output logic signed [61:0] out_frequency_offset
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_MUL1, ST_SETC, ST_DIFF, ST_DIV, ST_RATE,
    ST_MUL2, ST_PREC, ST_WSEC, ST_FOFF
  } state_t;

  state_t             state_r;
  logic [63:0]        clock_r;
  logic [63:0]        rate_r;
  logic [31:0]        ticks_r;
  logic [63:0]        ref_r;
  logic [63:0]        acc_r;
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r;
  logic [5:0]         cnt_r;
  logic [7:0]         sub_r;
  logic [31:0]        secs_r;
  logic [31:0]        offs_r;
  logic               out_valid_r;
  logic [31:0]        whole_r;
  logic [63:0]        prec_r;
  logic [31:0]        tick_out_r;
  logic [61:0]        foff_r;

  sfc_pkg::alu_req_t  alu_req;
  logic [63:0]        alu_sum;
  logic               alu_carry;

  // shared adder
  sfc_addsub u_alu (
    .req   (alu_req),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // operand selection per sequencer step
  always_comb begin
    alu_req = '{a: 64'd0, b: 64'd0, sub: 1'b0};
    case (state_r)
      ST_TICK: begin
        alu_req = '{a: clock_r, b: rate_r, sub: 1'b0};
      end
      ST_MUL1, ST_MUL2: begin
        alu_req = '{a: {acc_r[62:0], 1'b0},
                    b: (sub_r[cnt_r[2:0]] ? rate_r : 64'd0), sub: 1'b0};
      end
      ST_SETC: begin
        alu_req = '{a: {secs_r, 32'd0}, b: {8'd0, acc_r[63:8]}, sub: 1'b1};
      end
      ST_DIFF: begin
        alu_req = '{a: clock_r, b: ref_r, sub: 1'b1};
      end
      ST_DIV: begin
        alu_req = '{a: {31'd0, rem_r, dvd_r[63]}, b: {32'd0, ticks_r}, sub: 1'b1};
      end
      ST_RATE: begin
        alu_req = '{a: {{32{offs_r[31]}}, offs_r}, b: sfc_pkg::ONE_SEC, sub: 1'b0};
      end
      ST_PREC: begin
        alu_req = '{a: clock_r, b: {8'd0, acc_r[63:8]}, sub: 1'b0};
      end
      ST_WSEC: begin
        alu_req = '{a: {32'd0, clock_r[63:32]}, b: {61'd0, sub_r[7:5]}, sub: 1'b0};
      end
      ST_FOFF: begin
        alu_req = '{a: {3'd0, rate_r[63:3]}, b: sfc_pkg::ONE_SEC, sub: 1'b1};
      end
      default: begin
        alu_req = '{a: 64'd0, b: 64'd0, sub: 1'b0};
      end
    endcase
  end

  // sequencer, clock state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clock_r     <= 64'd0;
      rate_r      <= sfc_pkg::RATE_RESET;
      ticks_r     <= 32'd0;
      ref_r       <= 64'd0;
    end else begin
      // result taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sub_r  <= in_subcount;
            secs_r <= in_set_seconds;
            offs_r <= in_rate_offset;
            acc_r  <= 64'd0;
            cnt_r  <= sfc_pkg::MUL_START;
            case (in_mode)
              sfc_pkg::MODE_TICK: state_r <= ST_TICK;
              sfc_pkg::MODE_READ: state_r <= ST_MUL2;
              sfc_pkg::MODE_SET:  state_r <= ST_MUL1;
              sfc_pkg::MODE_RATE: state_r <= ST_RATE;
              default:            state_r <= ST_MUL2;
            endcase
          end
        end
        // advance the clock by one tick
        ST_TICK: begin
          clock_r <= alu_sum;
          ticks_r <= ticks_r + 32'd1;
          state_r <= ST_MUL2;
        end
        // sub-count product with the old rate
        ST_MUL1: begin
          acc_r <= alu_sum;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= ST_SETC;
          end
        end
        // load the clock, then recalibrate or take a new reference
        ST_SETC: begin
          clock_r <= alu_sum;
          acc_r   <= 64'd0;
          cnt_r   <= sfc_pkg::MUL_START;
          if ((ref_r != 64'd0) && (ticks_r != 32'd0)) begin
            state_r <= ST_DIFF;
          end else begin
            ref_r   <= alu_sum;
            ticks_r <= 32'd0;
            state_r <= ST_MUL2;
          end
        end
        // elapsed time since the reference
        ST_DIFF: begin
          dvd_r   <= alu_sum;
          rem_r   <= 32'd0;
          cnt_r   <= sfc_pkg::DIV_START;
          state_r <= ST_DIV;
        end
        // restoring divide, one quotient bit a cycle
        ST_DIV: begin
          rem_r <= alu_carry ? alu_sum[31:0] : {rem_r[30:0], dvd_r[63]};
          dvd_r <= {dvd_r[62:0], alu_carry};
          if (cnt_r == 6'd0) begin
            rate_r  <= {dvd_r[62:0], alu_carry};
            acc_r   <= 64'd0;
            cnt_r   <= sfc_pkg::MUL_START;
            state_r <= ST_MUL2;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        // rate from signed offset
        ST_RATE: begin
          rate_r  <= {alu_sum[60:0], 3'd0};
          state_r <= ST_MUL2;
        end
        // sub-count product with the current rate
        ST_MUL2: begin
          acc_r <= alu_sum;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= ST_PREC;
          end
        end
        // readback, once the previous result has gone
        ST_PREC: begin
          if (!out_valid_r) begin
            prec_r  <= alu_sum;
            state_r <= ST_WSEC;
          end
        end
        ST_WSEC: begin
          whole_r <= alu_sum[31:0];
          state_r <= ST_FOFF;
        end
        ST_FOFF: begin
          foff_r      <= alu_sum[61:0];
          tick_out_r  <= ticks_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_whole_seconds    = whole_r;
  assign out_precise_time     = prec_r;
  assign out_tick_count       = tick_out_r;
  assign out_frequency_offset = foff_r;

endmodule

>>> src/sfc_checker.sv
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks of the fractional clock unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "self_calibrating_fractional_clock_unit_assert.svh"

module sfc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a waiting result is not withdrawn
  `SFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // an accepted item keeps the block busy
  `SFC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // a result never appears the cycle after an item is taken
  `SFC_ASSERT_IMP(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready),
                  "result too early")

endmodule

bind self_calibrating_fractional_clock_unit sfc_checker u_sfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractional clock unit. A short table of
// directed items (extremes, every mode, reference and divide guards) runs
// first. Random calibration runs, rate loads and noise items follow. Each
// result is checked field by field against an in-bench model of the clock, or
// a fixed readback where the table gives one, with random gaps and stalls on
// both channels.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1200;
  localparam int N_SCHED      = 25;

  // one readback of the clock
  typedef struct packed {
    logic [31:0] whole;
    logic [63:0] precise;
    logic [31:0] ticks;
    logic [61:0] freq;
  } clock_reading_t;

  // one row of the directed schedule
  typedef struct packed {
    logic [1:0]     mode;
    logic [7:0]     sub;
    logic [31:0]    secs;
    logic [31:0]    offs;
    logic           typed;
    clock_reading_t want;
  } sched_row_t;

  localparam clock_reading_t READ_ZERO = '{32'd0, 64'd0, 32'd0, 62'd0};

  // directed schedule: fixed readbacks only where they are obvious
  localparam sched_row_t SCHED [0:N_SCHED-1] = '{
    '{sfc_pkg::MODE_READ, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, READ_ZERO},
    '{sfc_pkg::MODE_READ, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'd7, 64'h0000_0007_F800_0000, 32'd0, 62'd0}},
    '{sfc_pkg::MODE_TICK, 8'd0,   32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
      '{32'd8, 64'h0000_0008_0000_0000, 32'd1, 62'd0}},
    '{sfc_pkg::MODE_SET,  8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, READ_ZERO},
    '{sfc_pkg::MODE_TICK, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_SET,  8'd0,   32'd100,       32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_SET,  8'd0,   32'd100,       32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd31,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd32,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_READ, 8'd128, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd128, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd255, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_SET,  8'd0,   32'd140,       32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_READ, 8'd128, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_RATE, 8'd0,   32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd255, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_RATE, 8'd255, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd64,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_RATE, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_SET,  8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd255, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_TICK, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_SET,  8'd255, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{sfc_pkg::MODE_RATE, 8'd1,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{sfc_pkg::MODE_READ, 8'd224, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic [7:0]         in_subcount;
  logic [31:0]        in_set_seconds;
  logic signed [31:0] in_rate_offset;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        out_whole_seconds;
  logic [63:0]        out_precise_time;
  logic [31:0]        out_tick_count;
  logic signed [61:0] out_frequency_offset;

  // model state of the clock
  logic [63:0] tod_clock;
  logic [63:0] tod_rate;
  logic [31:0] tod_ticks;
  logic [63:0] tod_ref;

  clock_reading_t pending_readings [$];
  clock_reading_t oldest_reading;
  bit             no_stall;
  int             n_errors;
  int             n_checked;
  int             n_recal;
  int             n_mode [4];

  self_calibrating_fractional_clock_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_subcount          (in_subcount),
    .in_set_seconds       (in_set_seconds),
    .in_rate_offset       (in_rate_offset),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_whole_seconds    (out_whole_seconds),
    .out_precise_time     (out_precise_time),
    .out_tick_count       (out_tick_count),
    .out_frequency_offset (out_frequency_offset)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  initial begin
    #(20_000_000);
    $display("self_calibrating_fractional_clock_unit test failed");
    $finish;
  end

  // interpolation across the sub-count, wrapping at 64 bits
  function automatic logic [63:0] sub_fraction(input logic [7:0] sub, input logic [63:0] rate);
    logic [63:0] prod;
    prod = {56'd0, sub} * rate;
    return prod >> 8;
  endfunction

  // apply one item to the model clock and return its readback
  function automatic clock_reading_t advance_clock(input logic [1:0] mode, input logic [7:0] sub,
                                                   input logic [31:0] secs,
                                                   input logic [31:0] offs);
    clock_reading_t r;
    logic [63:0]    freq_full;
    case (mode)
      sfc_pkg::MODE_TICK: begin
        tod_clock = tod_clock + tod_rate;
        tod_ticks = tod_ticks + 32'd1;
      end
      sfc_pkg::MODE_SET: begin
        tod_clock = {secs, 32'd0} - sub_fraction(sub, tod_rate);
        if (tod_ref != 64'd0 && tod_ticks != 32'd0) begin
          tod_rate = (tod_clock - tod_ref) / {32'd0, tod_ticks};
          n_recal++;
        end else begin
          tod_ref   = tod_clock;
          tod_ticks = 32'd0;
        end
      end
      sfc_pkg::MODE_RATE: begin
        tod_rate = ({{32{offs[31]}}, offs} + sfc_pkg::ONE_SEC) << 3;
      end
      default: ;
    endcase
    freq_full  = (tod_rate >> 3) - sfc_pkg::ONE_SEC;
    r.whole    = tod_clock[63:32] + {29'd0, sub[7:5]};
    r.precise  = tod_clock + sub_fraction(sub, tod_rate);
    r.ticks    = tod_ticks;
    r.freq     = freq_full[61:0];
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // present one item and hold it until accepted
  task automatic drive_item(input logic [1:0] mode, input logic [7:0] sub,
                            input logic [31:0] secs, input logic [31:0] offs);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_subcount    <= sub;
    in_set_seconds <= secs;
    in_rate_offset <= offs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_mode[mode]++;
  endtask

  // optional sender gap after an accepted item
  task automatic idle_sender();
    int gap;
    gap = no_stall ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send one item predicted by the model
  task automatic issue(input logic [1:0] mode, input logic [7:0] sub,
                       input logic [31:0] secs, input logic [31:0] offs);
    drive_item(mode, sub, secs, offs);
    pending_readings.push_back(advance_clock(mode, sub, secs, offs));
    idle_sender();
  endtask

  // random item of a given mode
  task automatic issue_rand(input logic [1:0] mode);
    issue(mode, 8'($urandom_range(0, 255)), $urandom(), $urandom());
  endtask

  // hold off the sender until every readback is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // set time, a run of ticks with some reads, then a second set time that recalibrates
  task automatic calibration_run();
    logic [31:0] t0;
    logic [31:0] t1;
    int          n;
    t0 = $urandom();
    n  = $urandom_range(1, 12);
    issue(sfc_pkg::MODE_SET, 8'($urandom_range(0, 255)), t0, $urandom());
    for (int i = 0; i < n; i++) begin
      issue_rand(sfc_pkg::MODE_TICK);
      if ($urandom_range(0, 3) == 0) issue_rand(sfc_pkg::MODE_READ);
    end
    // mostly a plausible elapsed time, sometimes anything
    if ($urandom_range(0, 9) < 7) t1 = t0 + 32'(n * $urandom_range(1, 16));
    else t1 = $urandom();
    issue(sfc_pkg::MODE_SET, 8'($urandom_range(0, 255)), t1, $urandom());
    repeat ($urandom_range(0, 3))
      issue_rand($urandom_range(0, 1) ? sfc_pkg::MODE_TICK : sfc_pkg::MODE_READ);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no item outstanding");
        n_errors++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        check_field("whole_seconds", 64'(oldest_reading.whole), 64'(out_whole_seconds));
        check_field("precise_time", oldest_reading.precise, out_precise_time);
        check_field("tick_count", 64'(oldest_reading.ticks), 64'(out_tick_count));
        check_field("frequency_offset", 64'(oldest_reading.freq),
                    64'($unsigned(out_frequency_offset)));
        n_checked++;
      end
    end
  end

  // result side: runs of ready broken by random stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      gap = no_stall ? 0 : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // main sequence
  initial begin
    int sent;
    int r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = sfc_pkg::MODE_READ;
    in_subcount    = 8'd0;
    in_set_seconds = 32'd0;
    in_rate_offset = 32'sd0;
    no_stall       = 1'b0;
    n_errors       = 0;
    n_checked      = 0;
    n_recal        = 0;
    foreach (n_mode[i]) n_mode[i] = 0;
    tod_clock      = 64'd0;
    tod_rate       = sfc_pkg::RATE_RESET;
    tod_ticks      = 32'd0;
    tod_ref        = 64'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed schedule
    for (int i = 0; i < N_SCHED; i++) begin
      clock_reading_t predicted;
      drive_item(SCHED[i].mode, SCHED[i].sub, SCHED[i].secs, SCHED[i].offs);
      predicted = advance_clock(SCHED[i].mode, SCHED[i].sub, SCHED[i].secs, SCHED[i].offs);
      pending_readings.push_back(SCHED[i].typed ? SCHED[i].want : predicted);
      idle_sender();
    end
    drain();

    // random part: mostly calibration runs, some rate loads and noise
    sent = n_mode[0] + n_mode[1] + n_mode[2] + n_mode[3];
    while (n_mode[0] + n_mode[1] + n_mode[2] + n_mode[3] < sent + RANDOM_ITEMS) begin
      no_stall = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 39) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        calibration_run();
      end else if (r < 75) begin
        issue_rand(sfc_pkg::MODE_RATE);
        repeat ($urandom_range(1, 6))
          issue_rand($urandom_range(0, 2) != 0 ? sfc_pkg::MODE_TICK : sfc_pkg::MODE_READ);
      end else begin
        repeat ($urandom_range(1, 8)) issue_rand(2'($urandom_range(0, 3)));
      end
    end
    no_stall = 1'b0;

    // let the tail drain, then watch for stray results
    drain();
    repeat (100) @(posedge clk);
    $display("ran %0d ticks, %0d reads, %0d set-time (%0d recalibrations), %0d set-rate",
             n_mode[sfc_pkg::MODE_TICK], n_mode[sfc_pkg::MODE_READ],
             n_mode[sfc_pkg::MODE_SET], n_recal, n_mode[sfc_pkg::MODE_RATE]);
    $display("%0d readbacks checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("self_calibrating_fractional_clock_unit test passed");
    end else begin
      $display("self_calibrating_fractional_clock_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sfc_pkg.sv
src/sfc_addsub.sv
src/self_calibrating_fractional_clock_unit.sv
src/sfc_checker.sv
verif/tb_top.sv
